@@ hw/rtl/abmi_pkg.sv @@
// ----------------------------------------------------------------------------
// abmi_pkg
// Shared types and constants for the affine bone matrix inverse pipeline.
// ----------------------------------------------------------------------------
package abmi_pkg;

  typedef logic signed [31:0] fx_t;
  typedef logic [11:0][31:0] mat_t;
  typedef logic [8:0][31:0] blk_t;
  typedef logic [2:0][31:0] vec_t;
  typedef logic [2:0][63:0] sum_t;

  localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;

  // quotient never exceeds 2^32, so 33 bits of it are enough
  localparam int DIV_STEPS = 33;

endpackage

@@ hw/rtl/affine_bone_matrix_inverse_top.sv @@
// ----------------------------------------------------------------------------
// affine_bone_matrix_inverse_top
// Inverse of a scaled-orthogonal 3x4 affine matrix in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: drive the twelve in_ fields (row-major, translation in column 3)
// and pulse start; a word is taken at every edge where start is high and busy
// is low. busy is always low, so one matrix may enter every cycle.
// The pipeline: 3 stages form magnitudes, squares and column sums, 33
// stages of the divider pipeline produce one quotient bit each, one stage
// saturates, and 3 stages build the new translation. Throughput is one matrix
// per cycle, set by the nine divider pipelines working side by side.
// The result word appears on the out_ ports for exactly one cycle with
// out_valid high; the receiver cannot stall, so nothing is held back.
// A zero-length axis gives the positive limit in the three linear elements of its output row.
// Synchronous reset clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module affine_bone_matrix_inverse_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  abmi_pkg::fx_t in_r0c0, input abmi_pkg::fx_t in_r0c1,
  input  abmi_pkg::fx_t in_r0c2, input abmi_pkg::fx_t in_r0c3,
  input  abmi_pkg::fx_t in_r1c0, input abmi_pkg::fx_t in_r1c1,
  input  abmi_pkg::fx_t in_r1c2, input abmi_pkg::fx_t in_r1c3,
  input  abmi_pkg::fx_t in_r2c0, input abmi_pkg::fx_t in_r2c1,
  input  abmi_pkg::fx_t in_r2c2, input abmi_pkg::fx_t in_r2c3,
  output logic out_valid,
  output abmi_pkg::fx_t out_inv_r0c0, output abmi_pkg::fx_t out_inv_r0c1,
  output abmi_pkg::fx_t out_inv_r0c2, output abmi_pkg::fx_t out_inv_r0c3,
  output abmi_pkg::fx_t out_inv_r1c0, output abmi_pkg::fx_t out_inv_r1c1,
  output abmi_pkg::fx_t out_inv_r1c2, output abmi_pkg::fx_t out_inv_r1c3,
  output abmi_pkg::fx_t out_inv_r2c0, output abmi_pkg::fx_t out_inv_r2c1,
  output abmi_pkg::fx_t out_inv_r2c2, output abmi_pkg::fx_t out_inv_r2c3
);
  import abmi_pkg::*;

  localparam int TD = DIV_STEPS + 1;

  mat_t       a;
  logic       fv;
  blk_t       mag;
  logic [8:0] neg;
  sum_t       s;
  logic [2:0] z;
  vec_t       t;
  logic [8:0] dv;
  blk_t       u;
  vec_t       td_r [TD];
  logic       xv;
  mat_t       res;

  assign busy = 1'b0;
  assign a = {in_r2c3, in_r2c2, in_r2c1, in_r2c0, in_r1c3, in_r1c2, in_r1c1, in_r1c0,
              in_r0c3, in_r0c2, in_r0c1, in_r0c0};

  abmi_front u_front (
    .clk(clk), .rst_n(rst_n), .v_i(start && !busy), .a_i(a),
    .v_o(fv), .mag_o(mag), .neg_o(neg), .s_o(s), .z_o(z), .t_o(t)
  );

  // output element (i,j) divides input element (j,i) by column i's sum
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      abmi_div u_div (
        .clk(clk), .rst_n(rst_n), .v_i(fv),
        .mag_i(mag[j*3+i]), .neg_i(neg[j*3+i]), .s_i(s[i]), .z_i(z[i]),
        .v_o(dv[i*3+j]), .q_o(u[i*3+j])
      );
    end
  end

  always_ff @(posedge clk) begin
    td_r[0] <= t;
    for (int k = 1; k < TD; k++) begin
      td_r[k] <= td_r[k-1];
    end
  end

  abmi_xlate u_xlate (
    .clk(clk), .rst_n(rst_n), .v_i(dv[0]), .u_i(u), .t_i(td_r[TD-1]),
    .v_o(xv), .res_o(res)
  );

  assign out_valid    = xv;
  assign out_inv_r0c0 = res[0];
  assign out_inv_r0c1 = res[1];
  assign out_inv_r0c2 = res[2];
  assign out_inv_r0c3 = res[3];
  assign out_inv_r1c0 = res[4];
  assign out_inv_r1c1 = res[5];
  assign out_inv_r1c2 = res[6];
  assign out_inv_r1c3 = res[7];
  assign out_inv_r2c0 = res[8];
  assign out_inv_r2c1 = res[9];
  assign out_inv_r2c2 = res[10];
  assign out_inv_r2c3 = res[11];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##40 out_valid)
    else $error("word lost in pipeline");

  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_r0c0 == 0 && in_r1c0 == 0 && in_r2c0 == 0
      |-> ##40 out_inv_r0c0 == FX_MAX && out_inv_r0c2 == FX_MAX)
    else $error("zero axis not saturated");

  a_unit_axis: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_r0c0 == 32'sh00010000 && in_r1c0 == 0 && in_r2c0 == 0
      |-> ##40 out_inv_r0c0 == 32'sh00010000 && out_inv_r0c1 == 0)
    else $error("unit axis not preserved");

endmodule

@@ hw/rtl/abmi_front.sv @@
// ----------------------------------------------------------------------------
// abmi_front
// Magnitudes, squares and per-column sums of squares, three register stages.
// ----------------------------------------------------------------------------
module abmi_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_i,
  input  abmi_pkg::mat_t     a_i,
  output logic               v_o,
  output abmi_pkg::blk_t     mag_o,
  output logic [8:0]         neg_o,
  output abmi_pkg::sum_t     s_o,
  output logic [2:0]         z_o,
  output abmi_pkg::vec_t     t_o
);
  import abmi_pkg::*;

  logic       va_r, vb_r, vc_r;
  blk_t       maga_r, magb_r, magc_r;
  logic [8:0] nega_r, negb_r, negc_r;
  vec_t       ta_r, tb_r, tc_r;
  logic [8:0][63:0] sq_r;
  sum_t       s_r;
  logic [2:0] z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= v_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      ta_r[r] <= a_i[r*4+3];
      for (int c = 0; c < 3; c++) begin
        nega_r[r*3+c] <= a_i[r*4+c][31];
        maga_r[r*3+c] <= a_i[r*4+c][31] ? (32'd0 - a_i[r*4+c]) : a_i[r*4+c];
      end
    end
    magb_r <= maga_r;
    negb_r <= nega_r;
    tb_r   <= ta_r;
    for (int k = 0; k < 9; k++) begin
      sq_r[k] <= 64'(maga_r[k]) * 64'(maga_r[k]);
    end
    magc_r <= magb_r;
    negc_r <= negb_r;
    tc_r   <= tb_r;
    for (int c = 0; c < 3; c++) begin
      s_r[c] <= sq_r[c] + sq_r[3+c] + sq_r[6+c];
      z_r[c] <= (sq_r[c] | sq_r[3+c] | sq_r[6+c]) == 64'd0;
    end
  end

  assign v_o   = vc_r;
  assign mag_o = magc_r;
  assign neg_o = negc_r;
  assign s_o   = s_r;
  assign z_o   = z_r;
  assign t_o   = tc_r;

endmodule

@@ hw/rtl/abmi_div.sv @@
// ----------------------------------------------------------------------------
// abmi_div
// Pipelined restoring divider: |mag| * 2^32 / s, one quotient bit per stage,
// then sign and saturation to Q16.16.
// ----------------------------------------------------------------------------
module abmi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_i,
  input  logic [31:0]        mag_i,
  input  logic               neg_i,
  input  logic [63:0]        s_i,
  input  logic               z_i,
  output logic               v_o,
  output abmi_pkg::fx_t      q_o
);
  import abmi_pkg::*;

  localparam int N = DIV_STEPS;

  logic [N-1:0]       v_r;
  logic [63:0]        r_r   [N];
  logic [N-1:0]       q_r   [N];
  logic [63:0]        s_r   [N];
  logic [N-1:0]       neg_r;
  logic [N-1:0]       z_r;
  logic               vo_r;
  fx_t                q_out_r;

  logic [63:0]        r_in  [N];
  logic [N-1:0]       q_in  [N];
  logic [63:0]        s_in  [N];
  logic [64:0]        trial [N];
  logic [64:0]        diff  [N];

  // dividend is mag << 32: only its lowest magnitude bit enters after the seed
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        r_in[k]  = {33'd0, mag_i[31:1]};
        q_in[k]  = '0;
        s_in[k]  = s_i;
        trial[k] = {r_in[k], mag_i[0]};
      end else begin
        r_in[k]  = r_r[k-1];
        q_in[k]  = q_r[k-1];
        s_in[k]  = s_r[k-1];
        trial[k] = {r_in[k], 1'b0};
      end
      diff[k] = trial[k] - {1'b0, s_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[N-2:0], v_i};
      vo_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      s_r[k] <= s_in[k];
      if (trial[k] >= {1'b0, s_in[k]}) begin
        r_r[k] <= diff[k][63:0];
        q_r[k] <= {q_in[k][N-2:0], 1'b1};
      end else begin
        r_r[k] <= trial[k][63:0];
        q_r[k] <= {q_in[k][N-2:0], 1'b0};
      end
    end
    neg_r <= {neg_r[N-2:0], neg_i};
    z_r   <= {z_r[N-2:0], z_i};
    if (z_r[N-1]) begin
      q_out_r <= FX_MAX;
    end else if (neg_r[N-1]) begin
      q_out_r <= (q_r[N-1] > 33'h080000000) ? FX_MIN : fx_t'(33'd0 - q_r[N-1]);
    end else begin
      q_out_r <= (q_r[N-1] > 33'h07fffffff) ? FX_MAX : fx_t'(q_r[N-1]);
    end
  end

  assign v_o = vo_r;
  assign q_o = q_out_r;

endmodule

@@ hw/rtl/abmi_xlate.sv @@
// ----------------------------------------------------------------------------
// abmi_xlate
// New translation: products, sum, negate and saturate, three register stages.
// ----------------------------------------------------------------------------
module abmi_xlate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_i,
  input  abmi_pkg::blk_t     u_i,
  input  abmi_pkg::vec_t     t_i,
  output logic               v_o,
  output abmi_pkg::mat_t     res_o
);
  import abmi_pkg::*;

  logic             va_r, vb_r, vc_r;
  logic [8:0][63:0] p_r;
  blk_t             ua_r, ub_r;
  logic signed [65:0] sum_r [3];
  mat_t             res_r;

  logic signed [65:0] h    [3];
  logic signed [66:0] nh   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h[i]  = sum_r[i] >>> 16;
      nh[i] = 67'sd0 - 67'(h[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= v_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_r[i*3+j] <= 64'($signed(u_i[i*3+j]) * $signed(t_i[j]));
      end
    end
    ua_r <= u_i;
    // full products are summed before the shift, so only the sum is floored
    for (int i = 0; i < 3; i++) begin
      sum_r[i] <= 66'($signed(p_r[i*3])) + 66'($signed(p_r[i*3+1]))
                + 66'($signed(p_r[i*3+2]));
    end
    ub_r <= ua_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        res_r[i*4+j] <= ub_r[i*3+j];
      end
      if (nh[i] > 67'(FX_MAX)) begin
        res_r[i*4+3] <= FX_MAX;
      end else if (nh[i] < 67'(FX_MIN)) begin
        res_r[i*4+3] <= FX_MIN;
      end else begin
        res_r[i*4+3] <= nh[i][31:0];
      end
    end
  end

  assign v_o   = vc_r;
  assign res_o = res_r;

endmodule
